FILE: rtl/core/stc_pkg.sv
// shared types, character codes and helper functions for the statement tracker
package stc_pkg;

    localparam int unsigned STC_MAX_DEPTH = 255;

    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_VT    = 8'd11;
    localparam logic [7:0] CH_FF    = 8'd12;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_RBRK  = 8'h5D;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_LBRC  = 8'h7B;
    localparam logic [7:0] CH_RBRC  = 8'h7D;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_O     = 8'h6F;
    localparam logic [7:0] CH_T     = 8'h74;

    localparam logic [1:0] LS_MORE    = 2'd0;
    localparam logic [1:0] LS_DONE    = 2'd1;
    localparam logic [1:0] LS_BLANK   = 2'd2;
    localparam logic [1:0] LS_COMMENT = 2'd3;

    localparam logic [1:0] TK_NONE   = 2'd0;
    localparam logic [1:0] TK_ASSIGN = 2'd1;
    localparam logic [1:0] TK_COMMA  = 2'd2;
    localparam logic [1:0] TK_OPER   = 2'd3;

    localparam logic [2:0] RUN_MAX = 3'd4;
    localparam logic [2:0] RUN_NOT = 3'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       clear;
    } t_beat;

    typedef struct packed {
        logic [1:0] line_status;
        logic       open_string;
        logic [7:0] open_parens;
        logic [7:0] open_brackets;
        logic [7:0] open_braces;
        logic [1:0] trailing_kind;
    } t_result;

    function automatic logic is_blank(input logic [7:0] b);
        return (b == CH_TAB) || (b == CH_VT) || (b == CH_FF) || (b == CH_SPACE);
    endfunction

    function automatic logic is_name(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) ||
               (b >= 8'h30 && b <= 8'h39) || (b == CH_UNDER) || (b == CH_DOT);
    endfunction

    function automatic logic [1:0] trailing_kind(
        input logic       str_open,
        input logic [7:0] last,
        input logic [7:0] prev,
        input logic [2:0] run_len,
        input logic       run_not
    );
        logic [1:0] k;
        k = TK_NONE;
        if (str_open || last == CH_NUL) begin
            k = TK_NONE;
        end else if (last == CH_EQ) begin
            if (prev == CH_EQ || prev == CH_BANG || prev == CH_LT || prev == CH_GT) begin
                k = TK_OPER;
            end else begin
                k = TK_ASSIGN;
            end
        end else if (last == CH_COMMA) begin
            k = TK_COMMA;
        end else if (run_len == RUN_NOT && run_not) begin
            k = TK_OPER;
        end else if (last == CH_PLUS || last == CH_STAR || last == CH_SLASH ||
                     last == CH_PCT || last == CH_LT || last == CH_GT ||
                     last == CH_MINUS) begin
            k = TK_OPER;
        end
        return k;
    endfunction

endpackage

FILE: rtl/core/stc_in_stage.sv
// input register holding one accepted beat until the tracker takes it
module stc_in_stage
    import stc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_beat i_beat,
    input  logic  i_advance,
    output logic  o_valid,
    output t_beat o_beat
);

    logic  r_valid;
    t_beat r_beat;

    assign o_stall = r_valid & ~i_advance;
    assign o_valid = r_valid;
    assign o_beat  = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_beat <= i_beat;
        end
    end

endmodule

FILE: rtl/core/stc_tracker.sv
// line state, bracket depths, string mode and end-of-line decision
module stc_tracker
    import stc_pkg::*;
#(
    parameter int unsigned MAX_DEPTH = STC_MAX_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_beat   i_beat,
    output logic    o_produces,
    output t_result o_result
);

    localparam int unsigned DW = $clog2(MAX_DEPTH + 1);
    localparam logic [DW-1:0] DEPTH_TOP = DW'(MAX_DEPTH);
    localparam logic [DW-1:0] DEPTH_ONE = DW'(1);

    typedef enum logic [1:0] {
        PH_START,
        PH_BODY,
        PH_COMMENT,
        PH_CUT
    } t_phase;

    logic [DW-1:0] r_paren, n_paren;
    logic [DW-1:0] r_brack, n_brack;
    logic [DW-1:0] r_brace, n_brace;
    logic          r_str, n_str;
    logic          r_esc, n_esc;
    logic [7:0]    r_last, n_last;
    logic [7:0]    r_before, n_before;
    logic [7:0]    r_prev, n_prev;
    logic [7:0]    r_held, n_held;
    logic [2:0]    r_run, n_run;
    logic          r_run_not, n_run_not;
    logic          r_pending, n_pending;
    t_phase        r_phase, n_phase;

    logic [7:0]    b;
    logic          line_end;
    logic          esc_in;
    logic [7:0]    prev_in;
    logic [DW-1:0] a_paren, a_brack, a_brace;
    logic          a_str, a_esc;
    logic [7:0]    a_last, a_before;
    logic [2:0]    a_run, run_base;
    logic          a_run_not, run_cont, run_match;
    logic [1:0]    kind;
    logic          done;

    assign b          = i_beat.data_byte;
    assign line_end   = (b == CH_LF) || (b == CH_CR);
    assign o_produces = line_end & ~i_beat.clear;
    assign kind       = trailing_kind(r_str, r_last, r_before, r_run, r_run_not);

    // held leading whitespace goes in just ahead of the first visible byte
    assign esc_in  = (r_phase == PH_START && r_held != CH_NUL) ? 1'b0 : r_esc;
    assign prev_in = (r_phase == PH_START && r_held != CH_NUL) ? r_held : r_prev;

    always_comb begin
        a_paren   = r_paren;
        a_brack   = r_brack;
        a_brace   = r_brace;
        a_str     = r_str;
        a_esc     = esc_in;
        a_last    = r_last;
        a_before  = r_before;
        a_run     = r_run;
        a_run_not = r_run_not;
        run_cont  = is_name(prev_in) && (r_run != 3'd0);
        run_base  = run_cont ? r_run : 3'd0;
        run_match = run_cont ? r_run_not : 1'b1;
        if (esc_in) begin
            a_esc = 1'b0;
        end else if (r_str) begin
            if (b == CH_BSL) begin
                a_esc = 1'b1;
            end else if (b == CH_QUOTE) begin
                a_str = 1'b0;
            end
        end else begin
            case (b)
                CH_QUOTE: a_str = 1'b1;
                CH_LPAR:  if (r_paren < DEPTH_TOP) a_paren = r_paren + DEPTH_ONE;
                CH_RPAR:  if (r_paren != '0) a_paren = r_paren - DEPTH_ONE;
                CH_LBRK:  if (r_brack < DEPTH_TOP) a_brack = r_brack + DEPTH_ONE;
                CH_RBRK:  if (r_brack != '0) a_brack = r_brack - DEPTH_ONE;
                CH_LBRC:  if (r_brace < DEPTH_TOP) a_brace = r_brace + DEPTH_ONE;
                CH_RBRC:  if (r_brace != '0) a_brace = r_brace - DEPTH_ONE;
                default: ;
            endcase
        end
        if (!is_blank(b)) begin
            if (is_name(b)) begin
                a_run = (run_base < RUN_MAX) ? run_base + 3'd1 : run_base;
                case (a_run)
                    3'd1:    a_run_not = (b == CH_N);
                    3'd2:    a_run_not = run_match && (b == CH_O);
                    3'd3:    a_run_not = run_match && (b == CH_T);
                    default: a_run_not = 1'b0;
                endcase
            end else begin
                a_run     = 3'd0;
                a_run_not = 1'b0;
            end
            a_before = prev_in;
            a_last   = b;
        end
    end

    always_comb begin
        n_paren   = r_paren;
        n_brack   = r_brack;
        n_brace   = r_brace;
        n_str     = r_str;
        n_esc     = r_esc;
        n_last    = r_last;
        n_before  = r_before;
        n_prev    = r_prev;
        n_held    = r_held;
        n_run     = r_run;
        n_run_not = r_run_not;
        n_pending = r_pending;
        n_phase   = r_phase;
        done      = 1'b0;

        o_result.open_string   = r_str;
        o_result.open_parens   = 8'(r_paren);
        o_result.open_brackets = 8'(r_brack);
        o_result.open_braces   = 8'(r_brace);
        o_result.line_status   = LS_MORE;
        o_result.trailing_kind = TK_NONE;

        if (r_phase == PH_COMMENT) begin
            o_result.line_status   = LS_COMMENT;
            o_result.trailing_kind = kind;
        end else if (!r_pending) begin
            o_result.line_status   = LS_BLANK;
        end else begin
            o_result.trailing_kind = kind;
            done = (r_paren == '0) && (r_brack == '0) && (r_brace == '0) &&
                   !r_str && (kind == TK_NONE);
            o_result.line_status = done ? LS_DONE : LS_MORE;
        end

        if (!i_beat.clear && !line_end) begin
            case (r_phase)
                PH_START: begin
                    if (is_blank(b)) begin
                        n_held = b;
                    end else if (b == CH_NUL) begin
                        n_phase = PH_CUT;
                    end else if (b == CH_BSL && !r_str) begin
                        n_phase = PH_COMMENT;
                    end else begin
                        n_phase   = PH_BODY;
                        n_pending = 1'b1;
                    end
                end
                PH_BODY: begin
                    if (b == CH_NUL) begin
                        n_phase = PH_CUT;
                    end
                end
                default: ;
            endcase
            if ((r_phase == PH_START && !is_blank(b) && b != CH_NUL &&
                 !(b == CH_BSL && !r_str)) ||
                (r_phase == PH_BODY && b != CH_NUL)) begin
                n_paren   = a_paren;
                n_brack   = a_brack;
                n_brace   = a_brace;
                n_str     = a_str;
                n_esc     = a_esc;
                n_last    = a_last;
                n_before  = a_before;
                n_prev    = b;
                n_run     = a_run;
                n_run_not = a_run_not;
            end
        end else if (!i_beat.clear) begin
            n_phase = PH_START;
            n_held  = CH_NUL;
            if (r_phase != PH_COMMENT && r_pending) begin
                n_esc  = 1'b0;
                n_prev = CH_LF;
            end
        end

        if (i_beat.clear || (line_end && done)) begin
            n_paren   = '0;
            n_brack   = '0;
            n_brace   = '0;
            n_str     = 1'b0;
            n_esc     = 1'b0;
            n_last    = CH_NUL;
            n_before  = CH_NUL;
            n_prev    = CH_NUL;
            n_held    = CH_NUL;
            n_run     = 3'd0;
            n_run_not = 1'b0;
            n_pending = 1'b0;
            n_phase   = PH_START;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_paren   <= '0;
            r_brack   <= '0;
            r_brace   <= '0;
            r_str     <= 1'b0;
            r_esc     <= 1'b0;
            r_last    <= CH_NUL;
            r_before  <= CH_NUL;
            r_prev    <= CH_NUL;
            r_held    <= CH_NUL;
            r_run     <= 3'd0;
            r_run_not <= 1'b0;
            r_pending <= 1'b0;
            r_phase   <= PH_START;
        end else if (i_fire) begin
            r_paren   <= n_paren;
            r_brack   <= n_brack;
            r_brace   <= n_brace;
            r_str     <= n_str;
            r_esc     <= n_esc;
            r_last    <= n_last;
            r_before  <= n_before;
            r_prev    <= n_prev;
            r_held    <= n_held;
            r_run     <= n_run;
            r_run_not <= n_run_not;
            r_pending <= n_pending;
            r_phase   <= n_phase;
        end
    end

endmodule

FILE: rtl/core/stc_out_stage.sv
// result register toward the downstream side
module stc_out_stage
    import stc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    output logic    o_free,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_free   = ~r_valid | ~i_stall;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_result <= i_result;
        end
    end

endmodule

FILE: rtl/core/statement_completeness_tracker_top.sv
// top level of the statement completeness tracker
//
//  channel | direction | handshake                 | payload
//  in      | input     | i_in_valid / o_in_stall   | i_data_byte, i_clear
//  out     | output    | o_out_valid / i_out_stall | line status, depths, string, trailing
//
// one beat per cycle unless a line end meets a stalled result; results are registered
// the path between input register and result register is the byte scan and line-end decision
// synchronous active-low reset clears all tracking state; no clearing pass
// a stalled result stops the input only when the waiting beat is a line end
module statement_completeness_tracker_top
    import stc_pkg::*;
#(
    parameter int unsigned MAX_DEPTH = STC_MAX_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_clear,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_line_status,
    output logic       o_open_string,
    output logic [7:0] o_open_parens,
    output logic [7:0] o_open_brackets,
    output logic [7:0] o_open_braces,
    output logic [1:0] o_trailing_kind
);

    t_beat   in_beat;
    t_beat   q_beat;
    logic    q_valid;
    logic    produces;
    logic    out_free;
    logic    advance;
    logic    fire;
    t_result result;
    t_result out_result;

    assign in_beat.data_byte = i_data_byte;
    assign in_beat.clear     = i_clear;
    assign advance           = ~produces | out_free;
    assign fire              = q_valid & advance;

    stc_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_stall   (o_in_stall),
        .i_beat    (in_beat),
        .i_advance (advance),
        .o_valid   (q_valid),
        .o_beat    (q_beat)
    );

    stc_tracker #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_trk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_beat     (q_beat),
        .o_produces (produces),
        .o_result   (result)
    );

    stc_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (fire & produces),
        .i_result (result),
        .o_free   (out_free),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_result (out_result)
    );

    assign o_line_status   = out_result.line_status;
    assign o_open_string   = out_result.open_string;
    assign o_open_parens   = out_result.open_parens;
    assign o_open_brackets = out_result.open_brackets;
    assign o_open_braces   = out_result.open_braces;
    assign o_trailing_kind = out_result.trailing_kind;

endmodule

FILE: rtl/core/stc_checker.sv
// port-level checks for the statement completeness tracker, bound to the top level
module stc_checker
    import stc_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [1:0] o_line_status,
    input logic       o_open_string,
    input logic [7:0] o_open_parens,
    input logic [7:0] o_open_brackets,
    input logic [7:0] o_open_braces,
    input logic [1:0] o_trailing_kind
);

    a_done_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_line_status == LS_DONE) |->
        (!o_open_string && o_open_parens == 8'd0 && o_open_brackets == 8'd0 &&
         o_open_braces == 8'd0 && o_trailing_kind == TK_NONE))
        else $error("complete statement reported with open state");

    a_blank_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_line_status == LS_BLANK) |->
        (!o_open_string && o_open_parens == 8'd0 && o_open_brackets == 8'd0 &&
         o_open_braces == 8'd0 && o_trailing_kind == TK_NONE))
        else $error("blank line reported with nonzero fields");

    a_string_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_open_string) |-> (o_trailing_kind == TK_NONE))
        else $error("trailing kind reported inside an open string");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_line_status)))
        else $error("stalled result beat changed");

endmodule

bind statement_completeness_tracker_top stc_checker u_stc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_line_status   (o_line_status),
    .o_open_string   (o_open_string),
    .o_open_parens   (o_open_parens),
    .o_open_brackets (o_open_brackets),
    .o_open_braces   (o_open_braces),
    .o_trailing_kind (o_trailing_kind)
);

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// self-checking testbench for the statement completeness tracker, with predictor and scoreboard
module tb_top;
    import stc_pkg::*;

    typedef enum logic [1:0] {PH_START, PH_BODY, PH_COMMENT, PH_CUT} t_line_phase;

    localparam logic [7:0] CH_ETX = 8'd3;
    localparam logic [7:0] CH_BS  = 8'd8;
    localparam logic [7:0] CH_DEL = 8'd127;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic [7:0] in_byte   = 8'd0;
    logic       in_clear  = 1'b0;
    logic       out_stall = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic [1:0] line_status;
    logic       open_string;
    logic [7:0] open_parens;
    logic [7:0] open_brackets;
    logic [7:0] open_braces;
    logic [1:0] trailing_kind;

    logic [7:0]  depth_paren;
    logic [7:0]  depth_brack;
    logic [7:0]  depth_brace;
    logic        quote_open;
    logic        esc_armed;
    logic [7:0]  last_vis;
    logic [7:0]  before_vis;
    logic [7:0]  prior_byte;
    logic [7:0]  lead_ws;
    logic [2:0]  run_len;
    logic        run_not;
    logic        stmt_open;
    t_line_phase line_ph;

    t_beat   beat_q[$];
    t_result line_q[$];
    int      loaded       = 0;
    int      err_cnt      = 0;
    int      tx_idle_pct  = 0;
    int      rx_stall_pct = 0;

    statement_completeness_tracker_top u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_data_byte     (in_byte),
        .i_clear         (in_clear),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_line_status   (line_status),
        .o_open_string   (open_string),
        .o_open_parens   (open_parens),
        .o_open_brackets (open_brackets),
        .o_open_braces   (open_braces),
        .o_trailing_kind (trailing_kind)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic ws_byte(input logic [7:0] b);
        return b == CH_TAB || b == CH_VT || b == CH_FF || b == CH_SPACE;
    endfunction

    function automatic logic word_byte(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
               (b >= "0" && b <= "9") || b == CH_UNDER || b == CH_DOT;
    endfunction

    function automatic logic [1:0] tail_kind();
        if (quote_open || last_vis == CH_NUL) return TK_NONE;
        if (last_vis == CH_EQ) begin
            if (before_vis inside {CH_EQ, CH_BANG, CH_LT, CH_GT}) return TK_OPER;
            return TK_ASSIGN;
        end
        if (last_vis == CH_COMMA) return TK_COMMA;
        if (run_len == RUN_NOT && run_not) return TK_OPER;
        if (last_vis inside {CH_PLUS, CH_STAR, CH_SLASH, CH_PCT, CH_LT, CH_GT, CH_MINUS})
            return TK_OPER;
        return TK_NONE;
    endfunction

    task automatic tracker_clear();
        depth_paren = 8'd0;
        depth_brack = 8'd0;
        depth_brace = 8'd0;
        quote_open  = 1'b0;
        esc_armed   = 1'b0;
        last_vis    = CH_NUL;
        before_vis  = CH_NUL;
        prior_byte  = CH_NUL;
        lead_ws     = CH_NUL;
        run_len     = 3'd0;
        run_not     = 1'b0;
        stmt_open   = 1'b0;
        line_ph     = PH_START;
    endtask

    task automatic tracker_apply(input logic [7:0] b);
        logic       cont;
        logic [2:0] len;
        logic       hit;
        if (esc_armed) begin
            esc_armed = 1'b0;
        end else if (quote_open) begin
            if (b == CH_BSL) begin
                esc_armed = 1'b1;
            end else if (b == CH_QUOTE) begin
                quote_open = 1'b0;
            end
        end else begin
            case (b)
                CH_QUOTE: quote_open = 1'b1;
                CH_LPAR:  if (depth_paren < STC_MAX_DEPTH) depth_paren++;
                CH_RPAR:  if (depth_paren > 0) depth_paren--;
                CH_LBRK:  if (depth_brack < STC_MAX_DEPTH) depth_brack++;
                CH_RBRK:  if (depth_brack > 0) depth_brack--;
                CH_LBRC:  if (depth_brace < STC_MAX_DEPTH) depth_brace++;
                CH_RBRC:  if (depth_brace > 0) depth_brace--;
                default: ;
            endcase
        end
        if (!ws_byte(b)) begin
            if (word_byte(b)) begin
                cont = word_byte(prior_byte) && run_len != 3'd0;
                len  = cont ? run_len : 3'd0;
                hit  = cont ? run_not : 1'b1;
                if (len < RUN_MAX) len++;
                case (len)
                    3'd1:    hit = (b == CH_N);
                    3'd2:    hit = hit && (b == CH_O);
                    3'd3:    hit = hit && (b == CH_T);
                    default: hit = 1'b0;
                endcase
                run_len = len;
                run_not = hit;
            end else begin
                run_len = 3'd0;
                run_not = 1'b0;
            end
            before_vis = prior_byte;
            last_vis   = b;
        end
        prior_byte = b;
    endtask

    task automatic tracker_beat(input t_beat bt);
        t_result    r;
        logic [7:0] b;
        b = bt.data_byte;
        if (bt.clear) begin
            tracker_clear();
            return;
        end
        if (b != CH_LF && b != CH_CR) begin
            case (line_ph)
                PH_START: begin
                    if (ws_byte(b)) begin
                        lead_ws = b;
                    end else if (b == CH_NUL) begin
                        line_ph = PH_CUT;
                    end else if (b == CH_BSL && !quote_open) begin
                        line_ph = PH_COMMENT;
                    end else begin
                        line_ph   = PH_BODY;
                        stmt_open = 1'b1;
                        if (lead_ws != CH_NUL) tracker_apply(lead_ws);
                        tracker_apply(b);
                    end
                end
                PH_BODY: begin
                    if (b == CH_NUL) begin
                        line_ph = PH_CUT;
                    end else begin
                        tracker_apply(b);
                    end
                end
                default: ;
            endcase
            return;
        end
        if (line_ph == PH_COMMENT) begin
            r.line_status   = LS_COMMENT;
            r.trailing_kind = tail_kind();
        end else if (!stmt_open) begin
            r.line_status   = LS_BLANK;
            r.trailing_kind = TK_NONE;
        end else begin
            esc_armed       = 1'b0;
            prior_byte      = CH_LF;
            r.trailing_kind = tail_kind();
            if (depth_paren == 0 && depth_brack == 0 && depth_brace == 0 && !quote_open &&
                r.trailing_kind == TK_NONE) begin
                r.line_status = LS_DONE;
            end else begin
                r.line_status = LS_MORE;
            end
        end
        r.open_string   = quote_open;
        r.open_parens   = depth_paren;
        r.open_brackets = depth_brack;
        r.open_braces   = depth_brace;
        line_q.push_back(r);
        if (r.line_status == LS_DONE) begin
            tracker_clear();
        end else begin
            line_ph = PH_START;
            lead_ws = CH_NUL;
        end
    endtask

    task automatic put(input logic [7:0] b, input logic clr);
        t_beat bt;
        bt.data_byte = b;
        bt.clear     = clr;
        beat_q.push_back(bt);
        loaded++;
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) put(s[i], 1'b0);
    endtask

    function automatic logic [7:0] any_ws();
        case ($urandom_range(0, 3))
            0:       return CH_TAB;
            1:       return CH_VT;
            2:       return CH_FF;
            default: return CH_SPACE;
        endcase
    endfunction

    task automatic put_token();
        string name_set;
        name_set = "anotzAZ09_.q";
        case ($urandom_range(0, 11))
            0, 1: begin
                case ($urandom_range(0, 7))
                    0:       put_text("not");
                    1:       put_text("no");
                    2:       put_text("n");
                    3:       put_text("nott");
                    4:       put_text("knot");
                    5:       put_text("Not");
                    6:       put_text("a_1.b");
                    default: put_text("x9");
                endcase
            end
            2: repeat ($urandom_range(1, 5))
                put(name_set[$urandom_range(0, name_set.len() - 1)], 1'b0);
            3, 4: begin
                case ($urandom_range(0, 12))
                    0:       put_text("=");
                    1:       put_text("==");
                    2:       put_text("!=");
                    3:       put_text("<=");
                    4:       put_text(">=");
                    5:       put_text("+");
                    6:       put_text("-");
                    7:       put_text("*");
                    8:       put_text("/");
                    9:       put_text("%");
                    10:      put_text("<");
                    11:      put_text(">");
                    default: put_text(",");
                endcase
            end
            5: begin
                case ($urandom_range(0, 2))
                    0:       put(CH_LPAR, 1'b0);
                    1:       put(CH_LBRK, 1'b0);
                    default: put(CH_LBRC, 1'b0);
                endcase
            end
            6: begin
                case ($urandom_range(0, 2))
                    0:       put(CH_RPAR, 1'b0);
                    1:       put(CH_RBRK, 1'b0);
                    default: put(CH_RBRC, 1'b0);
                endcase
            end
            7: begin
                put(CH_QUOTE, 1'b0);
                repeat ($urandom_range(0, 5)) begin
                    if ($urandom_range(0, 4) == 0) put(CH_BSL, 1'b0);
                    put(8'($urandom_range(32, 126)), 1'b0);
                end
                if ($urandom_range(0, 5) != 0) put(CH_QUOTE, 1'b0);
            end
            8: put(any_ws(), 1'b0);
            9: begin
                case ($urandom_range(0, 3))
                    0:       put(CH_ETX, 1'b0);
                    1:       put(CH_BS, 1'b0);
                    2:       put(CH_DEL, 1'b0);
                    default: put(8'($urandom_range(128, 255)), 1'b0);
                endcase
            end
            10: put($urandom_range(0, 1) ? CH_QUOTE : CH_BSL, 1'b0);
            default: put(8'($urandom_range(33, 126)), 1'b0);
        endcase
    endtask

    task automatic note_bad(input string what);
        err_cnt++;
        if (err_cnt <= 10) $display("%0t %s", $time, what);
    endtask

    always @(posedge clk) begin : drive
        t_beat nxt;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !in_stall) begin
            if (in_valid) begin
                nxt.data_byte = in_byte;
                nxt.clear     = in_clear;
                tracker_beat(nxt);
            end
            if (beat_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                nxt = beat_q.pop_front();
                in_byte  <= nxt.data_byte;
                in_clear <= nxt.clear;
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin : watch
        t_result got;
        t_result want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                got = {line_status, open_string, open_parens, open_brackets, open_braces,
                       trailing_kind};
                if (line_q.size() == 0) begin
                    note_bad($sformatf({"unexpected line result st=%0d str=%0d par=%0d ",
                        "brk=%0d brc=%0d tk=%0d"},
                        got.line_status, got.open_string, got.open_parens, got.open_brackets,
                        got.open_braces, got.trailing_kind));
                end else begin
                    want = line_q.pop_front();
                    if (got.line_status !== want.line_status ||
                        got.open_string !== want.open_string ||
                        got.open_parens !== want.open_parens ||
                        got.open_brackets !== want.open_brackets ||
                        got.open_braces !== want.open_braces ||
                        got.trailing_kind !== want.trailing_kind) begin
                        note_bad($sformatf({"line result mismatch: want st=%0d str=%0d par=%0d ",
                            "brk=%0d brc=%0d tk=%0d, got st=%0d str=%0d par=%0d brk=%0d ",
                            "brc=%0d tk=%0d"},
                            want.line_status, want.open_string, want.open_parens,
                            want.open_brackets, want.open_braces, want.trailing_kind,
                            got.line_status, got.open_string, got.open_parens,
                            got.open_brackets, got.open_braces, got.trailing_kind));
                    end
                end
            end
            out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
        end
    end

    initial begin : main
        int         goal;
        int         pick;
        logic [7:0] open_ch;
        logic [7:0] close_ch;
        tracker_clear();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    tx_idle_pct  = 14;
                    rx_stall_pct = 72;
                end
                1: begin
                    tx_idle_pct  = 72;
                    rx_stall_pct = 14;
                end
                default: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
            endcase
            if (ph == 0) begin
                put_text("\t(\n");
                put_text(")\n");
                put(CH_LF, 1'b0);
                put_text(" \\x\n");
                put_text("\"a\\\n");
                put_text("\"=\r");
                put(8'hFF, 1'b1);
                put(8'hFF, 1'b0);
                put(CH_NUL, 1'b0);
                put_text("x\n");
                put_text("not\n");
            end
            // drive one bracket kind past its saturation point
            open_ch  = (ph == 0) ? CH_LPAR : (ph == 1) ? CH_LBRK : CH_LBRC;
            close_ch = (ph == 0) ? CH_RPAR : (ph == 1) ? CH_RBRK : CH_RBRC;
            put(CH_NUL, 1'b1);
            repeat (STC_MAX_DEPTH + 2) put(open_ch, 1'b0);
            put(CH_LF, 1'b0);
            put(close_ch, 1'b0);
            put(close_ch, 1'b0);
            put(CH_CR, 1'b0);
            put(CH_NUL, 1'b1);
            goal = loaded + 300;
            while (loaded < goal) begin
                pick = $urandom_range(0, 99);
                if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 3)) put(any_ws(), 1'b0);
                if (pick < 6) begin
                    put(CH_BSL, 1'b0);
                    repeat ($urandom_range(0, 3)) put_token();
                end else if (pick < 14) begin
                    repeat ($urandom_range(1, 8)) put(8'($urandom_range(0, 255)), 1'b0);
                end else if (pick >= 18) begin
                    repeat ($urandom_range(1, 6)) put_token();
                end
                if ($urandom_range(0, 14) == 0) begin
                    put(CH_NUL, 1'b0);
                    repeat ($urandom_range(0, 2)) put_token();
                end
                if ($urandom_range(0, 39) == 0) begin
                    put(8'($urandom_range(0, 255)), 1'b1);
                end else begin
                    put($urandom_range(0, 1) ? CH_LF : CH_CR, 1'b0);
                end
            end
            while (beat_q.size() != 0 || in_valid) @(posedge clk);
            while (line_q.size() != 0) @(posedge clk);
        end
        repeat (8) @(posedge clk);
        if (err_cnt == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
